[rtl/bbmh_pkg.sv]
// Shared types and constants for the b-bit minwise hash sketch.
// Used by every module in rtl/; depends on nothing.
package bbmh_pkg;

   localparam int MAX_BLOCKS    = 64;
   localparam int MAX_TERMS     = 8;
   localparam int MAX_HASH_BITS = 16;

   localparam int BLK_W  = $clog2(MAX_BLOCKS);
   localparam int TERM_W = $clog2(MAX_TERMS);
   localparam int VAL_W  = 31;
   localparam int MIN_W  = MAX_HASH_BITS;
   localparam int POS_W  = 22;
   localparam int CNT_W  = $clog2(VAL_W);

   localparam logic [VAL_W-1:0] MOD_RESET   = 31'h7FFF_FFFF;
   localparam logic [4:0]       BITS_RESET  = 5'd8;
   localparam logic [6:0]       BLKS_RESET  = 7'd16;
   localparam logic [3:0]       TERMS_RESET = 4'd4;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_FEATURE = 2'd1,
      CMD_END     = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_MODULUS = 2'd0,
      CSR_BITS    = 2'd1,
      CSR_BLOCKS  = 2'd2,
      CSR_TERMS   = 2'd3
   } csr_idx_type;

   // request to the serial modular multiplier: x * y mod p, y below p
   typedef struct packed {
      logic             start;
      logic [VAL_W-1:0] x;
      logic [VAL_W-1:0] y;
      logic [VAL_W-1:0] p;
   } mm_req_type;

   // control of one minimum cell
   typedef struct packed {
      logic shift;
      logic upd;
      logic clr;
   } cell_ctl_type;

endpackage

[rtl/bbmh_cell.sv]
// One cell of the rotating chain of per-block minima.
// Depends on bbmh_pkg.
module bbmh_cell import bbmh_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cell_ctl_type     ctl,
   input  logic [MIN_W-1:0] nbr,
   input  logic [MIN_W-1:0] cand,
   output logic [MIN_W-1:0] value
);

   logic [MIN_W-1:0] min_ff, min_in;

   // take the neighbor's value, lowered by the candidate or cleared
   always_comb begin
      min_in = min_ff;
      if (ctl.shift) begin
         if (ctl.clr)
            min_in = '1;
         else if (ctl.upd && (cand < nbr))
            min_in = cand;
         else
            min_in = nbr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         min_ff <= '1;
      else
         min_ff <= min_in;
   end

   assign value = min_ff;

endmodule

[rtl/bbmh_mulmod.sv]
// Bit-serial modular multiplier: x * y mod p, one bit of x per cycle.
// Depends on bbmh_pkg.
module bbmh_mulmod import bbmh_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  mm_req_type       req,
   output logic             done,
   output logic [VAL_W-1:0] result
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [VAL_W-1:0] acc_ff, acc_in;
   logic [VAL_W-1:0] x_ff, x_in;
   logic [VAL_W-1:0] y_ff, y_in;
   logic [VAL_W-1:0] p_ff, p_in;
   logic [VAL_W:0]   d1, d1r, d2, d2r, p_ext;

   // double, add the next bit's multiple, reduce twice
   always_comb begin
      p_ext = {1'b0, p_ff};
      d1    = {acc_ff, 1'b0};
      d1r   = (d1 >= p_ext) ? d1 - p_ext : d1;
      d2    = x_ff[VAL_W-1] ? d1r + {1'b0, y_ff} : d1r;
      d2r   = (d2 >= p_ext) ? d2 - p_ext : d2;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      p_in    = p_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(VAL_W - 1);
         acc_in  = '0;
         x_in    = req.x;
         y_in    = req.y;
         p_in    = req.p;
      end else if (busy_ff) begin
         acc_in = d2r[VAL_W-1:0];
         x_in   = {x_ff[VAL_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      p_ff   <= p_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

[rtl/b_bit_minwise_hash_sketch_top.sv]
// Top level of the b-bit minwise hash sketch: sequencer, coefficient memory,
// serial multiplier and the chain of minimum cells. Depends on bbmh_pkg,
// bbmh_cell and bbmh_mulmod.
//
// Usage:
//   req_* carries commands: load coefficient, feature index, end of vector.
//   rsp_* returns one beat per block after an end of vector, last on the
//   final block. csr_* writes modulus, hash bits, blocks and terms, idle only.
// Timing:
//   load: a write to the coefficient memory. feature: paced by the
//   bit-serial multiplier (one bit of 31 per cycle) doing two
//   products per term, Horner style, block after block.
//   end of vector: the chain rotates once around, frozen by receiver stalls;
//   the first result beat is registered once the sequencer is in emit.
//   req_ready is high only while the sequencer is idle.
// Reset:
//   synchronous; control and CSR registers to defaults, every minimum to all
//   ones, the vector to empty. The coefficient memory is not cleared.
// Stall:
//   a held rsp beat freezes the chain sweep until it is taken.
module b_bit_minwise_hash_sketch_top import bbmh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic [5:0]        req_block_index,
   input  logic [2:0]        req_term_index,
   input  logic [30:0]       req_coef_value,
   input  logic [30:0]       req_feature_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [POS_W-1:0]  rsp_position,
   output logic              rsp_last,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [30:0]       csr_wdata
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_REDT = 7'b0000010,
      ST_BLK  = 7'b0000100,
      ST_MUL  = 7'b0001000,
      ST_REDA = 7'b0010000,
      ST_CMP  = 7'b0100000,
      ST_EMIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [VAL_W-1:0] mod_ff;
   logic [4:0]       bits_ff;
   logic [6:0]       blks_ff;
   logic [3:0]       terms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff   <= MOD_RESET;
         bits_ff  <= BITS_RESET;
         blks_ff  <= BLKS_RESET;
         terms_ff <= TERMS_RESET;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MODULUS: mod_ff   <= csr_wdata;
            CSR_BITS:    bits_ff  <= csr_wdata[4:0];
            CSR_BLOCKS:  blks_ff  <= csr_wdata[6:0];
            CSR_TERMS:   terms_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // saturate registers to their working ranges
   logic [VAL_W-1:0] eff_p;
   logic [4:0]       eff_b;
   logic [6:0]       eff_l;
   logic [3:0]       eff_k;
   logic [MIN_W-1:0] hmask;

   always_comb begin
      eff_p = (mod_ff < VAL_W'(2)) ? VAL_W'(2) : mod_ff;
      eff_b = (bits_ff == '0) ? 5'd1 :
              (bits_ff > 5'(MAX_HASH_BITS)) ? 5'(MAX_HASH_BITS) : bits_ff;
      eff_l = (blks_ff == '0) ? 7'd1 :
              (blks_ff > 7'(MAX_BLOCKS)) ? 7'(MAX_BLOCKS) : blks_ff;
      eff_k = (terms_ff == '0) ? 4'd1 :
              (terms_ff > 4'(MAX_TERMS)) ? 4'(MAX_TERMS) : terms_ff;
      hmask = ~({MIN_W{1'b1}} << eff_b);
   end

   // coefficient memory, registered read
   logic [VAL_W-1:0] coef_mem [MAX_BLOCKS*MAX_TERMS];
   logic [VAL_W-1:0] rd_data_ff;
   logic [BLK_W-1:0] blk_ff, blk_in;
   logic [TERM_W-1:0] term_ff, term_in;
   logic             mem_we;

   always_ff @(posedge clock) begin
      if (mem_we)
         coef_mem[{req_block_index, req_term_index}] <= req_coef_value;
      rd_data_ff <= coef_mem[{blk_ff, term_ff}];
   end

   // serial multiplier
   mm_req_type       mm_req;
   logic             mm_done;
   logic [VAL_W-1:0] mm_res;

   bbmh_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .req    (mm_req),
      .done   (mm_done),
      .result (mm_res)
   );

   // chain of minimum cells, rotating toward cell 0
   logic [MIN_W-1:0] cell_val [MAX_BLOCKS];
   cell_ctl_type     tail_ctl;
   logic             chain_shift;
   logic [MIN_W-1:0] cand;

   for (genvar j = 0; j < MAX_BLOCKS; j++) begin : g_cell
      cell_ctl_type ctl;
      logic [MIN_W-1:0] nbr;
      if (j == MAX_BLOCKS - 1) begin : g_tail
         assign ctl = tail_ctl;
         assign nbr = cell_val[0];
      end else begin : g_body
         assign ctl = '{shift: chain_shift, upd: 1'b0, clr: 1'b0};
         assign nbr = cell_val[j+1];
      end
      bbmh_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .nbr   (nbr),
         .cand  (cand),
         .value (cell_val[j])
      );
   end

   // sequencer
   logic [VAL_W-1:0] tm_ff, tm_in;
   logic [VAL_W-1:0] tot_ff, tot_in;
   logic             nonempty_ff, nonempty_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             last_ff, last_in;
   logic [VAL_W:0]   sum, sum_r;
   logic             blk_live, blk_end, out_free;

   always_comb begin
      sum      = {1'b0, tot_ff} + {1'b0, mm_res};
      sum_r    = (sum >= {1'b0, eff_p}) ? sum - {1'b0, eff_p} : sum;
      blk_live = {1'b0, blk_ff} < eff_l;
      blk_end  = (blk_ff == BLK_W'(MAX_BLOCKS - 1));
      out_free = !rsp_valid_ff || rsp_ready;
      cand     = tot_ff[MIN_W-1:0] & hmask;
   end

   always_comb begin
      state_in     = state_ff;
      blk_in       = blk_ff;
      term_in      = term_ff;
      tm_in        = tm_ff;
      tot_in       = tot_ff;
      nonempty_in  = nonempty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pos_in       = pos_ff;
      last_in      = last_ff;
      mem_we       = 1'b0;
      chain_shift  = 1'b0;
      tail_ctl     = '{shift: 1'b0, upd: 1'b0, clr: 1'b0};
      mm_req       = '{start: 1'b0, x: req_feature_index, y: VAL_W'(1), p: eff_p};
      req_ready    = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               blk_in = '0;
               unique case (cmd_type'(req_cmd))
                  CMD_LOAD: mem_we = 1'b1;
                  CMD_FEATURE: begin
                     mm_req.start = 1'b1;
                     nonempty_in  = 1'b1;
                     state_in     = ST_REDT;
                  end
                  CMD_END: state_in = ST_EMIT;
                  default: ;
               endcase
            end
         end
         ST_REDT: begin
            if (mm_done) begin
               tm_in    = mm_res;
               state_in = ST_BLK;
            end
         end
         ST_BLK: begin
            if (blk_live) begin
               tot_in       = '0;
               term_in      = TERM_W'(eff_k - 1'b1);
               mm_req.start = 1'b1;
               mm_req.x     = '0;
               mm_req.y     = tm_ff;
               state_in     = ST_MUL;
            end else begin
               // rotate unused blocks without update
               chain_shift    = 1'b1;
               tail_ctl.shift = 1'b1;
               blk_in         = blk_ff + 1'b1;
               if (blk_end)
                  state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            if (mm_done) begin
               tot_in       = mm_res;
               mm_req.start = 1'b1;
               mm_req.x     = rd_data_ff;
               state_in     = ST_REDA;
            end
         end
         ST_REDA: begin
            if (mm_done) begin
               tot_in = sum_r[VAL_W-1:0];
               if (term_ff == '0) begin
                  state_in = ST_CMP;
               end else begin
                  term_in      = term_ff - 1'b1;
                  mm_req.start = 1'b1;
                  mm_req.x     = sum_r[VAL_W-1:0];
                  mm_req.y     = tm_ff;
                  state_in     = ST_MUL;
               end
            end
         end
         ST_CMP: begin
            chain_shift = 1'b1;
            tail_ctl    = '{shift: 1'b1, upd: 1'b1, clr: 1'b0};
            blk_in      = blk_ff + 1'b1;
            state_in    = blk_end ? ST_IDLE : ST_BLK;
         end
         ST_EMIT: begin
            if (!blk_live || out_free) begin
               chain_shift = 1'b1;
               tail_ctl    = '{shift: 1'b1, upd: 1'b0, clr: 1'b1};
               blk_in      = blk_ff + 1'b1;
               if (blk_live) begin
                  rsp_valid_in = 1'b1;
                  pos_in       = (POS_W'(blk_ff) << eff_b) +
                                 POS_W'(nonempty_ff ? (cell_val[0] & hmask) : '0);
                  last_in      = ({1'b0, blk_ff} + 7'd1) == eff_l;
               end
               if (blk_end) begin
                  nonempty_in = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         blk_ff       <= '0;
         term_ff      <= '0;
         nonempty_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         blk_ff       <= blk_in;
         term_ff      <= term_in;
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tm_ff   <= tm_in;
      tot_ff  <= tot_in;
      pos_ff  <= pos_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = pos_ff;
   assign rsp_last     = last_ff;

endmodule
